// ----- hdl/sequential_list_engine_assert.svh -----
// ---------------------------------------------------------------------------
// sequential_list_engine_assert.svh
// Assertion macros for the list engine; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_ENGINE_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define SLE_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);
`define SLE_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define SLE_ASSERT_IMP(lbl, pre, post, msg)
`define SLE_ASSERT_NXT(lbl, pre, post, msg)
`endif
`endif

// ----- hdl/sle_pkg.sv -----
// ---------------------------------------------------------------------------
// sle_pkg
// Shared types and constants of the list engine.
// ---------------------------------------------------------------------------
package sle_pkg;

	localparam int CAPACITY_DEF = 128;

	typedef enum logic [2:0] {
		REQ_INSERT = 3'd0,
		REQ_DELETE = 3'd1,
		REQ_LOCATE = 3'd2,
		REQ_GET    = 3'd3,
		REQ_SORT   = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD      = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_DEL,
		S_LOC,
		S_GET,
		S_SORT,
		S_FIN
	} state_t;

	typedef struct packed {
		status_t            status;
		logic [6:0]         found_index;
		logic signed [31:0] read_value;
		logic [7:0]         count;
	} res_t;

endpackage

// ----- hdl/sle_store.sv -----
// ---------------------------------------------------------------------------
// sle_store
// Element memory: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module sle_store
	import sle_pkg::*;
#(
	parameter int DEPTH = CAPACITY_DEF
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic signed [31:0]               wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic signed [31:0]               rdata
);

	logic signed [31:0] mem_q [DEPTH];
	logic signed [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/sle_seq.sv -----
// ---------------------------------------------------------------------------
// sle_seq
// Request sequencer: checks, shift walks, locate scan, get and bubble sort,
// all as streams of reads and writes through the element memory.
// ---------------------------------------------------------------------------
`include "sequential_list_engine_assert.svh"

module sle_seq
	import sle_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic [2:0]                       req_type,
	input  logic [7:0]                       position,
	input  logic signed [31:0]               value,
	output logic                             res_valid,
	output res_t                             res,
	input  logic                             out_free,
	output logic                             mem_we,
	output logic [$clog2(CAPACITY)-1:0]      mem_waddr,
	output logic signed [31:0]               mem_wdata,
	output logic                             mem_re,
	output logic [$clog2(CAPACITY)-1:0]      mem_raddr,
	input  logic signed [31:0]               mem_rdata
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > 8) ? CW : 8) + 1;

	state_t             state_q, state_d;
	logic [CW-1:0]      count_q, count_d;
	logic [CW-1:0]      idx_q, idx_d;
	logic [AW-1:0]      pm1_q, pm1_d;
	logic [AW-1:0]      last_q, last_d;
	logic signed [31:0] val_q, val_d;
	logic signed [31:0] cur_q, cur_d;
	logic               v_q, v_d;
	logic [AW-1:0]      rd_addr_s1;
	status_t            status_q, status_d;
	logic [AW-1:0]      found_q, found_d;
	logic signed [31:0] rdv_q, rdv_d;

	logic [XW-1:0]      pos_x, cnt_x, pm1_x, found_x;
	logic [CW-1:0]      idx_m1, idx_p1, cnt_m1;
	logic [AW-1:0]      rd_addr_p1, rd_addr_m1;

	assign pos_x      = XW'(position);
	assign cnt_x      = XW'(count_q);
	assign pm1_x      = pos_x - XW'(1);
	assign found_x    = XW'(found_q);
	assign idx_m1     = idx_q - CW'(1);
	assign idx_p1     = idx_q + CW'(1);
	assign cnt_m1     = count_q - CW'(1);
	assign rd_addr_p1 = rd_addr_s1 + AW'(1);
	assign rd_addr_m1 = rd_addr_s1 - AW'(1);

	assign res.status      = status_q;
	assign res.found_index = found_x[6:0];
	assign res.read_value  = rdv_q;
	assign res.count       = cnt_x[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			v_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			v_q     <= v_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		pm1_q    <= pm1_d;
		last_q   <= last_d;
		val_q    <= val_d;
		cur_q    <= cur_d;
		status_q <= status_d;
		found_q  <= found_d;
		rdv_q    <= rdv_d;
		if (mem_re) begin
			rd_addr_s1 <= mem_raddr;
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		pm1_d     = pm1_q;
		last_d    = last_q;
		val_d     = val_q;
		cur_d     = cur_q;
		v_d       = 1'b0;
		status_d  = status_q;
		found_d   = found_q;
		rdv_d     = rdv_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		req_ready = (state_q == S_IDLE);
		res_valid = (state_q == S_FIN);

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					val_d    = value;
					pm1_d    = pm1_x[AW-1:0];
					found_d  = '0;
					rdv_d    = '0;
					status_d = ST_OK;
					case (req_t'(req_type))
						REQ_INSERT: begin
							if (position == 8'd0 || pos_x > cnt_x + XW'(1)) begin
								status_d = ST_BAD;
								state_d  = S_FIN;
							end else if (count_q == CW'(CAPACITY)) begin
								status_d = ST_FULL;
								state_d  = S_FIN;
							end else begin
								idx_d   = count_q;
								state_d = S_INS;
							end
						end
						REQ_DELETE: begin
							if (position == 8'd0 || pos_x > cnt_x) begin
								status_d = ST_BAD;
								state_d  = S_FIN;
							end else begin
								idx_d   = pos_x[CW-1:0];
								state_d = S_DEL;
							end
						end
						REQ_LOCATE: begin
							idx_d    = '0;
							status_d = ST_NOTFOUND;
							state_d  = (count_q == '0) ? S_FIN : S_LOC;
						end
						REQ_GET: begin
							if (pos_x >= cnt_x) begin
								status_d = ST_BAD;
								state_d  = S_FIN;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = pos_x[AW-1:0];
								state_d   = S_GET;
							end
						end
						REQ_SORT: begin
							idx_d   = '0;
							last_d  = cnt_m1[AW-1:0];
							state_d = (count_q < CW'(2)) ? S_FIN : S_SORT;
						end
						default: begin
							status_d = ST_BAD;
							state_d  = S_FIN;
						end
					endcase
				end
			end
			S_INS: begin
				if (v_q) begin
					mem_we    = 1'b1;
					mem_waddr = rd_addr_p1;
					mem_wdata = mem_rdata;
				end
				if (idx_q > CW'(pm1_q)) begin
					mem_re    = 1'b1;
					mem_raddr = idx_m1[AW-1:0];
					idx_d     = idx_m1;
					v_d       = 1'b1;
				end else if (!v_q) begin
					mem_we    = 1'b1;
					mem_waddr = pm1_q;
					mem_wdata = val_q;
					count_d   = count_q + CW'(1);
					state_d   = S_FIN;
				end
			end
			S_DEL: begin
				if (v_q) begin
					mem_we    = 1'b1;
					mem_waddr = rd_addr_m1;
					mem_wdata = mem_rdata;
				end
				if (idx_q < count_q) begin
					mem_re    = 1'b1;
					mem_raddr = idx_q[AW-1:0];
					idx_d     = idx_p1;
					v_d       = 1'b1;
				end else if (!v_q) begin
					count_d = cnt_m1;
					state_d = S_FIN;
				end
			end
			S_LOC: begin
				if (v_q && mem_rdata == val_q) begin
					status_d = ST_OK;
					found_d  = rd_addr_s1;
				end
				if (v_q && mem_rdata >= val_q) begin
					state_d = S_FIN;
				end else if (idx_q < count_q) begin
					mem_re    = 1'b1;
					mem_raddr = idx_q[AW-1:0];
					idx_d     = idx_p1;
					v_d       = 1'b1;
				end else if (!v_q) begin
					state_d = S_FIN;
				end
			end
			S_GET: begin
				rdv_d   = mem_rdata;
				state_d = S_FIN;
			end
			S_SORT: begin
				// carry the running maximum; the smaller one settles behind it
				if (v_q) begin
					if (rd_addr_s1 == '0) begin
						cur_d = mem_rdata;
					end else begin
						mem_we    = 1'b1;
						mem_waddr = rd_addr_m1;
						mem_wdata = (cur_q > mem_rdata) ? mem_rdata : cur_q;
						cur_d     = (cur_q > mem_rdata) ? cur_q : mem_rdata;
					end
				end
				if (idx_q <= CW'(last_q)) begin
					mem_re    = 1'b1;
					mem_raddr = idx_q[AW-1:0];
					idx_d     = idx_p1;
					v_d       = 1'b1;
				end else if (!v_q) begin
					mem_we    = 1'b1;
					mem_waddr = last_q;
					mem_wdata = cur_q;
					idx_d     = '0;
					last_d    = last_q - AW'(1);
					if (last_q == AW'(1)) begin
						state_d = S_FIN;
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`SLE_ASSERT_IMP(a_no_rw_clash, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit one entry")
	`SLE_ASSERT_IMP(a_count_cap, 1'b1, count_q <= CW'(CAPACITY), "count above capacity")
	`SLE_ASSERT_IMP(a_fin_drained, state_q == S_FIN, !v_q, "read still in flight at finish")
	`SLE_ASSERT_IMP(a_count_src, count_q != $past(count_q), $past(state_q) == S_INS || $past(state_q) == S_DEL, "count changed outside insert or delete")
	`SLE_ASSERT_NXT(a_idle_hold, state_q == S_IDLE && !req_valid, state_q == S_IDLE && count_q == $past(count_q), "idle engine moved")

endmodule

// ----- hdl/sequential_list_engine.sv -----
// ---------------------------------------------------------------------------
// sequential_list_engine
// Array-backed list of signed 32-bit elements: insert, delete, locate, get
// and ascending sort, one result item per request item.
// ---------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)                               tuser
//  s_*      in   position[7:0] value[39:8]                        req_type[2:0]
//  m_*      out  found_index[6:0] read_value[38:7] count[46:39]  status[1:0]
//
//  Per item: insert shifts each entry from the position on up by one, delete
//  shifts each entry behind the position down by one, locate scans from the
//  front, get reads one entry and sort makes bubble passes; rejected requests
//  and locate on an empty list touch no entry. The single read port and single
//  write port of the element memory let one entry move or be compared per cycle.
//  Reset clears the count; memory contents stay undefined, no clearing pass.
//  A new item is taken while a result waits; a stalled result holds the
//  engine in its final step until the output register frees.
// ---------------------------------------------------------------------------
module sequential_list_engine
	import sle_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // position[7:0], value[39:8]
	input  logic [2:0]  s_tuser,   // req_type[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // found_index[6:0], read_value[38:7], count[46:39]
	output logic [1:0]  m_tuser    // status[1:0]
);

	localparam int AW = $clog2(CAPACITY);

	logic               res_valid;
	res_t               res;
	logic               out_free;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic signed [31:0] mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;
	logic signed [31:0] mem_rdata;

	logic               m_tvalid_q;
	logic [47:0]        m_tdata_q;
	logic [1:0]         m_tuser_q;

	assign out_free = !m_tvalid_q || m_tready;

	sle_seq #(
		.CAPACITY (CAPACITY)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req_type  (s_tuser),
		.position  (s_tdata[7:0]),
		.value     (s_tdata[39:8]),
		.res_valid (res_valid),
		.res       (res),
		.out_free  (out_free),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	sle_store #(
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			m_tdata_q <= {1'b0, res.count, res.read_value, res.found_index};
			m_tuser_q <= res.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ----- verif/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the list engine. A scoreboard class keeps its own
// copy of the list and count, predicts one result per accepted request and
// checks each returned result field by field. A short directed run covers
// empty-list, bad-position and unknown requests, then random runs with fill
// and drain biases cover the rest under varied sender idling, receiver
// stalls and one long receiver hold-off.
// ---------------------------------------------------------------------------
module testbench;
	import sle_pkg::*;

	localparam int CAP          = CAPACITY_DEF;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int HOLD_CYCLES  = 400;
	localparam int TAIL_CYCLES  = 300;
	localparam int REPORT_LIMIT = 10;

	localparam logic [2:0] REQ_RSVD5 = 3'd5;
	localparam logic [2:0] REQ_RSVD7 = 3'd7;

	localparam logic signed [31:0] VAL_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

	class list_scoreboard;
		logic signed [31:0] elems [CAP];
		int                 cnt;
		res_t               expected_q [$];
		int                 failures;

		function new();
			cnt = 0;
			failures = 0;
		endfunction

		function int outstanding();
			return expected_q.size();
		endfunction

		function void note_request(logic [2:0] kind, logic [7:0] pos,
				logic signed [31:0] val);
			res_t               r;
			int                 k;
			int                 p;
			int                 pass;
			logic signed [31:0] t;
			r = '0;
			r.status = ST_OK;
			p = pos;
			case (kind)
				REQ_INSERT: begin
					if (p < 1 || p > cnt + 1) begin
						r.status = ST_BAD;
					end else if (cnt >= CAP) begin
						r.status = ST_FULL;
					end else begin
						for (k = cnt; k > p - 1; k--)
							elems[k] = elems[k - 1];
						elems[p - 1] = val;
						cnt++;
					end
				end
				REQ_DELETE: begin
					if (p < 1 || p > cnt) begin
						r.status = ST_BAD;
					end else begin
						for (k = p - 1; k + 1 < cnt; k++)
							elems[k] = elems[k + 1];
						cnt--;
					end
				end
				REQ_LOCATE: begin
					r.status = ST_NOTFOUND;
					for (k = 0; k < cnt; k++) begin
						if (elems[k] < val)
							continue;
						if (elems[k] == val) begin
							r.status = ST_OK;
							r.found_index = k[6:0];
						end
						break;
					end
				end
				REQ_GET: begin
					if (p < cnt)
						r.read_value = elems[p];
					else
						r.status = ST_BAD;
				end
				REQ_SORT: begin
					for (pass = 0; pass < cnt - 1; pass++) begin
						for (k = 0; k + 1 < cnt - pass; k++) begin
							if (elems[k] > elems[k + 1]) begin
								t = elems[k];
								elems[k] = elems[k + 1];
								elems[k + 1] = t;
							end
						end
					end
				end
				default: r.status = ST_BAD;
			endcase
			r.count = cnt[7:0];
			expected_q.push_back(r);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_q.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("unexpected result item: status %0d idx %0d value %0d count %0d",
						got.status, got.found_index, got.read_value, got.count);
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status || got.found_index !== want.found_index ||
					got.read_value !== want.read_value || got.count !== want.count) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("mismatch: expected status %0d idx %0d value %0d count %0d, got status %0d idx %0d value %0d count %0d",
						want.status, want.found_index, want.read_value, want.count,
						got.status, got.found_index, got.read_value, got.count);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // position[7:0], value[39:8]
	logic [2:0]  s_tuser;   // req_type[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // found_index[6:0], read_value[38:7], count[46:39]
	logic [1:0]  m_tuser;   // status[1:0]

	list_scoreboard sb;
	int             idle_pct;
	int             stall_pct;
	logic           hold_request;
	logic           hold_done;
	int             cycles;

	sequential_list_engine i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		m_tready  = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.note_request(s_tuser, s_tdata[7:0], s_tdata[39:8]);
			if (m_tvalid && m_tready)
				sb.check_result('{status: status_t'(m_tuser), found_index: m_tdata[6:0],
					read_value: m_tdata[38:7], count: m_tdata[46:39]});
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

	// entered and left at a falling edge
	task automatic send_item(logic [2:0] kind, logic [7:0] pos, logic signed [31:0] val);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {val, pos};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
	endtask

	function automatic logic signed [31:0] any_value();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return $signed($urandom_range(16)) - 8;
		if (r < 50) begin
			case ($urandom_range(3))
				0: return VAL_MAX;
				1: return VAL_MIN;
				2: return 0;
				default: return -1;
			endcase
		end
		return $urandom;
	endfunction

	task automatic pick_request(int ins_w, int del_w, output logic [2:0] kind,
			output logic [7:0] pos, output logic signed [31:0] val);
		int r;
		int n;
		n = sb.cnt;
		r = $urandom_range(99);
		pos = 8'($urandom);
		val = $urandom;
		if (r < ins_w) begin
			kind = REQ_INSERT;
			val = any_value();
			if ($urandom_range(99) < 85)
				pos = 8'($urandom_range(n + 1, 1));
			else
				pos = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, n + 2));
		end else if (r < ins_w + del_w) begin
			kind = REQ_DELETE;
			if (n > 0 && $urandom_range(99) < 85)
				pos = 8'($urandom_range(n, 1));
			else
				pos = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, n + 1));
		end else if (r < ins_w + del_w + 2) begin
			kind = REQ_SORT;
		end else if (r < ins_w + del_w + 4) begin
			kind = 3'($urandom_range(REQ_RSVD7, REQ_RSVD5));
		end else if ($urandom_range(1)) begin
			kind = REQ_LOCATE;
			if (n > 0 && $urandom_range(1))
				val = sb.elems[$urandom_range(n - 1)];
			else
				val = any_value();
		end else begin
			kind = REQ_GET;
			if (n > 0 && $urandom_range(99) < 80)
				pos = 8'($urandom_range(n - 1));
			else
				pos = 8'($urandom_range(255, n));
		end
	endtask

	task automatic run_phase(int items, int sender_idle, int recv_stall,
			int ins_w, int del_w);
		logic [2:0]         kind;
		logic [7:0]         pos;
		logic signed [31:0] val;
		idle_pct  = sender_idle;
		stall_pct = recv_stall;
		repeat (items) begin
			pick_request(ins_w, del_w, kind, pos, val);
			send_item(kind, pos, val);
		end
		wait_drained();
	endtask

	initial begin
		sb = new();
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		idle_pct     = 0;
		stall_pct    = 0;
		hold_request = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty list
		send_item(REQ_DELETE, 8'd1, 0);
		send_item(REQ_GET, 8'd0, 0);
		send_item(REQ_LOCATE, 8'd0, 0);
		send_item(REQ_SORT, 8'd0, 0);
		send_item(REQ_INSERT, 8'd0, 5);
		send_item(REQ_INSERT, 8'd2, 5);
		// build [min, -1, max, 0]
		send_item(REQ_INSERT, 8'd1, VAL_MAX);
		send_item(REQ_INSERT, 8'd1, VAL_MIN);
		send_item(REQ_INSERT, 8'd3, 0);
		send_item(REQ_INSERT, 8'd2, -1);
		send_item(REQ_INSERT, 8'd255, 7);
		send_item(REQ_LOCATE, 8'd0, VAL_MIN);
		send_item(REQ_LOCATE, 8'd0, 0);       // scan stops at max
		send_item(REQ_GET, 8'd3, 0);
		send_item(REQ_GET, 8'd4, 0);
		send_item(REQ_GET, 8'd255, 0);
		send_item(REQ_SORT, 8'd0, 0);
		send_item(REQ_LOCATE, 8'd0, VAL_MAX);
		send_item(REQ_LOCATE, 8'd0, 0);
		send_item(REQ_DELETE, 8'd0, 0);
		send_item(REQ_DELETE, 8'd5, 0);
		send_item(REQ_DELETE, 8'd255, 0);
		send_item(REQ_DELETE, 8'd4, 0);
		send_item(REQ_DELETE, 8'd1, 0);
		send_item(REQ_DELETE, 8'd1, 0);
		send_item(REQ_SORT, 8'd0, 0);         // single element
		send_item(REQ_RSVD5, 8'd255, -1);
		send_item(REQ_RSVD7, 8'd1, VAL_MAX);
		wait_drained();

		run_phase(200, 0, 0, 40, 25);
		run_phase(200, 58, 0, 40, 25);
		run_phase(250, 0, 58, 70, 5);         // fill up to capacity
		hold_request = 1'b1;
		run_phase(200, 35, 35, 30, 35);
		run_phase(150, 35, 35, 10, 70);       // drain to empty
		run_phase(100, 0, 0, 40, 25);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.outstanding() == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
